>>> hw/rtl/utf8_validating_char_counter_core_macros.svh
// Assertion macros for the UTF-8 validating character counter.
// Included by the core; no other dependencies.
`ifndef UTF8_VALIDATING_CHAR_COUNTER_CORE_MACROS_SVH
`define UTF8_VALIDATING_CHAR_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UTF8_VCC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8_vcc assertion failed");

// Next-cycle implication, disabled during reset.
`define UTF8_VCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8_vcc assertion failed");

`endif

>>> hw/rtl/utf8_vcc_pkg.sv
// Types and constants for the UTF-8 validating character counter.
// No dependencies; used by the stream interface and the core.
`timescale 1ns / 1ps

package utf8_vcc_pkg;

  localparam int unsigned COUNT_W = 13;
  localparam int unsigned CP_W    = 21;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;

  // Code point limits
  localparam logic [CP_W-1:0] FLOOR_2BYTE = 21'h00080;
  localparam logic [CP_W-1:0] FLOOR_3BYTE = 21'h00800;
  localparam logic [CP_W-1:0] FLOOR_4BYTE = 21'h10000;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h0d800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h0dfff;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10ffff;
  localparam logic [7:0]      CONT_MASK   = 8'h3f;

  // Sequence class: smallest legal value of the open sequence
  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_2BYTE = 2'd1,
    CLASS_3BYTE = 2'd2,
    CLASS_4BYTE = 2'd3
  } seq_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } text_item_t;

  typedef struct packed {
    logic               text_valid;
    logic [COUNT_W-1:0] char_count;
  } result_item_t;

  function automatic logic [CP_W-1:0] class_floor(input seq_class_t cls);
    logic [CP_W-1:0] floor_val;
    unique case (cls)
      CLASS_2BYTE: floor_val = FLOOR_2BYTE;
      CLASS_3BYTE: floor_val = FLOOR_3BYTE;
      default:     floor_val = FLOOR_4BYTE;
    endcase
    return floor_val;
  endfunction

endpackage

>>> hw/rtl/utf8_vcc_stream_if.sv
// Valid/ready stream interface carrying one payload struct.
// Payload types come from utf8_vcc_pkg.
`timescale 1ns / 1ps

interface utf8_vcc_stream_if #(
  parameter type payload_t = utf8_vcc_pkg::text_item_t
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/utf8_validating_char_counter_core.sv
// Channel   Dir  Payload                               Transaction
// text      in   data_byte[7:0], has_byte, is_last     one item of a text
// result    out  text_valid, char_count[12:0]          one per item with is_last
//
// One byte per cycle while text.ready is high: the decode state updates in the cycle
// a text item is taken; a result is registered and shows the cycle after its last item.
// text.ready drops only while a result is held and result.ready is low.
// Synchronous reset clears decode state and the result valid flag.
// Depends on utf8_vcc_pkg, utf8_vcc_stream_if and the macros header.
`timescale 1ns / 1ps
`include "utf8_validating_char_counter_core_macros.svh"

module utf8_validating_char_counter_core #(
  parameter int unsigned MAX_TEXT_BYTES = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  utf8_vcc_stream_if.sink          text,
  utf8_vcc_stream_if.source        result
);

  localparam int unsigned CNT_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned CP_W  = utf8_vcc_pkg::CP_W;

  // Decode state
  logic [1:0]               bytes_to_follow, bytes_to_follow_next;
  logic [CP_W-1:0]          codepoint_acc, codepoint_acc_next;
  utf8_vcc_pkg::seq_class_t min_class, min_class_next;
  logic [CNT_W-1:0]         byte_total, byte_total_next;
  logic [CNT_W-1:0]         chars_seen, chars_seen_next;
  logic                     error_seen, error_seen_next;

  // Result register
  logic                       res_valid;
  utf8_vcc_pkg::result_item_t res_payload;

  logic                       accept;
  logic [7:0]                 b;
  logic [CP_W-1:0]            cp_shift;
  logic                       text_ok;
  utf8_vcc_pkg::result_item_t res_next;

  // Assertion terms
  logic                       last_accept;
  logic                       state_idle;
  logic                       invalid_res;
  logic                       total_ok;

  assign text.ready     = !res_valid || result.ready;
  assign accept         = text.valid && text.ready;
  assign b              = text.payload.data_byte;
  assign cp_shift       = {codepoint_acc[CP_W-7:0], b[5:0] & utf8_vcc_pkg::CONT_MASK[5:0]};
  assign result.valid   = res_valid;
  assign result.payload = res_payload;

  assign last_accept = accept && text.payload.is_last;
  assign state_idle  = byte_total == '0 && chars_seen == '0 && !error_seen &&
                       bytes_to_follow == 2'd0;
  assign invalid_res = res_valid && !res_payload.text_valid;
  assign total_ok    = byte_total <= CNT_W'(MAX_TEXT_BYTES) && chars_seen <= byte_total;

  always_comb begin
    bytes_to_follow_next = bytes_to_follow;
    codepoint_acc_next   = codepoint_acc;
    min_class_next       = min_class;
    byte_total_next      = byte_total;
    chars_seen_next      = chars_seen;
    error_seen_next      = error_seen;

    if (accept && text.payload.has_byte && !error_seen) begin
      if (byte_total >= CNT_W'(MAX_TEXT_BYTES)) begin
        error_seen_next = 1'b1;
      end else begin
        byte_total_next = byte_total + CNT_W'(1);
        if (bytes_to_follow == 2'd0) begin
          priority if (b == 8'h00) begin
            error_seen_next = 1'b1;
          end else if (!b[7]) begin
            chars_seen_next = chars_seen + CNT_W'(1);
          end else if (b >= utf8_vcc_pkg::LEAD2_LO && b <= utf8_vcc_pkg::LEAD2_HI) begin
            codepoint_acc_next   = CP_W'(b[4:0]);
            min_class_next       = utf8_vcc_pkg::CLASS_2BYTE;
            bytes_to_follow_next = 2'd1;
          end else if (b >= utf8_vcc_pkg::LEAD3_LO && b <= utf8_vcc_pkg::LEAD3_HI) begin
            codepoint_acc_next   = CP_W'(b[3:0]);
            min_class_next       = utf8_vcc_pkg::CLASS_3BYTE;
            bytes_to_follow_next = 2'd2;
          end else if (b >= utf8_vcc_pkg::LEAD4_LO && b <= utf8_vcc_pkg::LEAD4_HI) begin
            codepoint_acc_next   = CP_W'(b[2:0]);
            min_class_next       = utf8_vcc_pkg::CLASS_4BYTE;
            bytes_to_follow_next = 2'd3;
          end else begin
            error_seen_next = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          error_seen_next = 1'b1;
        end else begin
          bytes_to_follow_next = bytes_to_follow - 2'd1;
          if (bytes_to_follow == 2'd1) begin
            // sequence complete: reject overlong, surrogate, out of range
            if (cp_shift < utf8_vcc_pkg::class_floor(min_class) ||
                (cp_shift >= utf8_vcc_pkg::SURR_LO && cp_shift <= utf8_vcc_pkg::SURR_HI) ||
                cp_shift > utf8_vcc_pkg::CP_MAX) begin
              error_seen_next = 1'b1;
            end else begin
              chars_seen_next = chars_seen + CNT_W'(1);
            end
            codepoint_acc_next = '0;
            min_class_next     = utf8_vcc_pkg::CLASS_NONE;
          end else begin
            codepoint_acc_next = cp_shift;
          end
        end
      end
    end

    text_ok             = !error_seen_next && (bytes_to_follow_next == 2'd0);
    res_next.text_valid = text_ok;
    res_next.char_count = text_ok ? utf8_vcc_pkg::COUNT_W'(chars_seen_next) : '0;

    if (accept && text.payload.is_last) begin
      bytes_to_follow_next = '0;
      codepoint_acc_next   = '0;
      min_class_next       = utf8_vcc_pkg::CLASS_NONE;
      byte_total_next      = '0;
      chars_seen_next      = '0;
      error_seen_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_to_follow <= '0;
      codepoint_acc   <= '0;
      min_class       <= utf8_vcc_pkg::CLASS_NONE;
      byte_total      <= '0;
      chars_seen      <= '0;
      error_seen      <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      bytes_to_follow <= bytes_to_follow_next;
      codepoint_acc   <= codepoint_acc_next;
      min_class       <= min_class_next;
      byte_total      <= byte_total_next;
      chars_seen      <= chars_seen_next;
      error_seen      <= error_seen_next;
      if (accept && text.payload.is_last) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.payload.is_last) begin
      res_payload <= res_next;
    end
  end

  `UTF8_VCC_ASSERT_NEXT(a_last_clears_state, clk, rst, last_accept, state_idle)
  `UTF8_VCC_ASSERT_NEXT(a_last_loads_result, clk, rst, last_accept, res_valid)
  `UTF8_VCC_ASSERT_NOW(a_invalid_zero_count, clk, rst, invalid_res, res_payload.char_count == '0)
  `UTF8_VCC_ASSERT_NOW(a_total_in_capacity, clk, rst, 1'b1, total_ok)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for utf8_validating_char_counter_core: a directed table, then
// random texts (mostly well-formed UTF-8, some broken), checked against a behavioral decoder.
// Depends on utf8_vcc_pkg, utf8_vcc_stream_if and the core.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_TEXT_BYTES = 4096;
  localparam int          RANDOM_ITEMS   = 1550;
  localparam int          CYCLE_LIMIT    = 1000000;
  localparam int          LONG_STALL     = 400;

  typedef enum int {
    FAULT_NONE, FAULT_NUL, FAULT_BAD_LEAD, FAULT_BAD_CONT, FAULT_TRUNC,
    FAULT_OVERLONG, FAULT_SURROGATE, FAULT_TOO_BIG, FAULT_NOISE
  } fault_t;

  // expectation typed in by hand; used instead of the decoder when pinned is set
  typedef struct packed {
    logic                       pinned;
    utf8_vcc_pkg::result_item_t res;
  } typed_result_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        is_last;
    logic        pinned;
    logic        ok;
    logic [12:0] count;
  } dir_row_t;

  localparam dir_row_t DIRECTED_TAB [0:26] = '{
    // empty text
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 13'd0},
    // ASCII extremes and two-byte extremes
    '{8'h7f, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'hc2, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'hdf, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'hbf, 1'b1, 1'b1, 1'b0, 1'b0, 13'd0},
    // zero byte
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0},
    // lead byte that can never start a sequence
    '{8'hc0, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0},
    // above 10FFFF
    '{8'hf4, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h90, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0},
    // overlong three-byte form
    '{8'he0, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0},
    // surrogate
    '{8'hed, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'ha0, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0},
    // truncated four-byte sequence, with an ignored item inside
    '{8'hf0, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h90, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0},
    // bad continuation, absorbed tail, text closed by an item without byte
    '{8'hef, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'ha5, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 13'd0}
  };

  logic clk;
  logic rst;

  utf8_vcc_stream_if #(.payload_t(utf8_vcc_pkg::text_item_t))   text_ch ();
  utf8_vcc_stream_if #(.payload_t(utf8_vcc_pkg::result_item_t)) result_ch ();

  utf8_validating_char_counter_core #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // decoder state
  int unsigned              dec_follow;
  logic [20:0]              dec_acc;
  utf8_vcc_pkg::seq_class_t dec_class;
  int unsigned              dec_bytes;
  int unsigned              dec_chars;
  bit                       dec_err;

  utf8_vcc_pkg::result_item_t expected_q [$];
  typed_result_t              typed_q [$];
  utf8_vcc_pkg::text_item_t   text_q [$];
  logic [7:0]                 byte_q [$];
  int                         results_seen;
  int                         mismatches;

  function automatic int idle_cycles(input bit burst);
    if (burst || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 9);
  endfunction

  // One text item through the decoder; done is set when the item closes the text.
  task automatic decode_item(input utf8_vcc_pkg::text_item_t it, output bit done,
                             output utf8_vcc_pkg::result_item_t r);
    logic [7:0]  b;
    logic [20:0] floor_cp;
    b    = it.data_byte;
    done = 1'b0;
    r    = '0;
    if (it.has_byte && !dec_err) begin
      if (dec_bytes >= MAX_TEXT_BYTES) begin
        dec_err = 1'b1;
      end else begin
        dec_bytes++;
        if (dec_follow == 0) begin
          if (b == 8'h00) begin
            dec_err = 1'b1;
          end else if (b < 8'h80) begin
            dec_chars++;
          end else if (b >= utf8_vcc_pkg::LEAD2_LO && b <= utf8_vcc_pkg::LEAD2_HI) begin
            dec_acc = {16'd0, b[4:0]};
            dec_class = utf8_vcc_pkg::CLASS_2BYTE;
            dec_follow = 1;
          end else if (b >= utf8_vcc_pkg::LEAD3_LO && b <= utf8_vcc_pkg::LEAD3_HI) begin
            dec_acc = {17'd0, b[3:0]};
            dec_class = utf8_vcc_pkg::CLASS_3BYTE;
            dec_follow = 2;
          end else if (b >= utf8_vcc_pkg::LEAD4_LO && b <= utf8_vcc_pkg::LEAD4_HI) begin
            dec_acc = {18'd0, b[2:0]};
            dec_class = utf8_vcc_pkg::CLASS_4BYTE;
            dec_follow = 3;
          end else begin
            dec_err = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          dec_err = 1'b1;
        end else begin
          dec_acc = {dec_acc[14:0], b[5:0]};
          dec_follow--;
          if (dec_follow == 0) begin
            case (dec_class)
              utf8_vcc_pkg::CLASS_2BYTE: floor_cp = 21'h00080;
              utf8_vcc_pkg::CLASS_3BYTE: floor_cp = 21'h00800;
              default:                   floor_cp = 21'h10000;
            endcase
            if (dec_acc < floor_cp ||
                (dec_acc >= utf8_vcc_pkg::SURR_LO && dec_acc <= utf8_vcc_pkg::SURR_HI) ||
                dec_acc > utf8_vcc_pkg::CP_MAX) begin
              dec_err = 1'b1;
            end else begin
              dec_chars++;
            end
            dec_acc = '0;
            dec_class = utf8_vcc_pkg::CLASS_NONE;
          end
        end
      end
    end
    if (it.is_last) begin
      done = 1'b1;
      r.text_valid = !dec_err && dec_follow == 0;
      r.char_count = r.text_valid ? dec_chars[12:0] : '0;
      dec_follow = 0;
      dec_acc = '0;
      dec_class = utf8_vcc_pkg::CLASS_NONE;
      dec_bytes = 0;
      dec_chars = 0;
      dec_err = 1'b0;
    end
  endtask

  // Legal code point of the given encoded length, sometimes at a range edge.
  function automatic logic [20:0] legal_cp(input int len);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    case (len)
      1:       begin lo = 21'h00001; hi = 21'h0007f; end
      2:       begin lo = 21'h00080; hi = 21'h007ff; end
      3:       begin lo = 21'h00800; hi = 21'h0ffff; end
      default: begin lo = 21'h10000; hi = 21'h10ffff; end
    endcase
    if ($urandom_range(0, 5) == 0) cp = $urandom_range(0, 1) ? hi : lo;
    else cp = 21'($urandom_range(hi, lo));
    if (cp >= utf8_vcc_pkg::SURR_LO && cp <= utf8_vcc_pkg::SURR_HI) cp = cp ^ 21'h04000;
    return cp;
  endfunction

  task automatic append_cp(input logic [20:0] cp, input int len);
    case (len)
      1: byte_q.push_back(cp[7:0]);
      2: begin
        byte_q.push_back({3'b110, cp[10:6]});
        byte_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        byte_q.push_back({4'b1110, cp[15:12]});
        byte_q.push_back({2'b10, cp[11:6]});
        byte_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        byte_q.push_back({5'b11110, cp[20:18]});
        byte_q.push_back({2'b10, cp[17:12]});
        byte_q.push_back({2'b10, cp[11:6]});
        byte_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic inject_fault(input fault_t fault);
    int len;
    int pos;
    len = $urandom_range(2, 4);
    case (fault)
      FAULT_NUL: byte_q.push_back(8'h00);
      FAULT_BAD_LEAD: begin
        case ($urandom_range(0, 2))
          0:       byte_q.push_back(8'($urandom_range(8'hbf, 8'h80)));
          1:       byte_q.push_back(8'($urandom_range(8'hc1, 8'hc0)));
          default: byte_q.push_back(8'($urandom_range(8'hff, 8'hf5)));
        endcase
      end
      FAULT_BAD_CONT: begin
        append_cp(legal_cp(len), len);
        pos = byte_q.size() - $urandom_range(1, len - 1);
        byte_q[pos] = $urandom_range(0, 1) ? 8'($urandom_range(8'h7f, 8'h00))
                                           : 8'($urandom_range(8'hff, 8'hc0));
      end
      FAULT_TRUNC: begin
        append_cp(legal_cp(len), len);
        repeat ($urandom_range(1, len - 1)) void'(byte_q.pop_back());
      end
      FAULT_OVERLONG: begin
        case (len)
          2:       append_cp(21'($urandom_range(21'h0007f, 0)), 2);
          3:       append_cp(21'($urandom_range(21'h007ff, 0)), 3);
          default: append_cp(21'($urandom_range(21'h0ffff, 0)), 4);
        endcase
      end
      FAULT_SURROGATE:
        append_cp(21'($urandom_range(utf8_vcc_pkg::SURR_HI, utf8_vcc_pkg::SURR_LO)), 3);
      FAULT_TOO_BIG:   append_cp(21'($urandom_range(21'h1fffff, 21'h110000)), 4);
      default: repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(255, 0)));
    endcase
  endtask

  // Random text into text_q: legal characters, at most one fault, ignored items mixed in.
  task automatic build_random_text();
    int                       nchars;
    int                       fault_at;
    fault_t                   fault;
    utf8_vcc_pkg::text_item_t it;
    int                       len;
    byte_q.delete();
    text_q.delete();
    nchars = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
    fault  = ($urandom_range(0, 3) == 0 && nchars > 0) ? fault_t'($urandom_range(1, 8))
                                                        : FAULT_NONE;
    fault_at = (fault == FAULT_TRUNC) ? nchars : $urandom_range(0, nchars);
    for (int i = 0; i <= nchars; i++) begin
      if (fault != FAULT_NONE && i == fault_at) inject_fault(fault);
      if (i < nchars) begin
        len = $urandom_range(1, 4);
        append_cp(legal_cp(len), len);
      end
    end
    foreach (byte_q[i]) begin
      if ($urandom_range(0, 7) == 0) begin
        it = '{data_byte: 8'($urandom_range(255, 0)), has_byte: 1'b0, is_last: 1'b0};
        text_q.push_back(it);
      end
      it = '{data_byte: byte_q[i], has_byte: 1'b1, is_last: 1'b0};
      text_q.push_back(it);
    end
    if (text_q.size() == 0 || $urandom_range(0, 3) == 0) begin
      it = '{data_byte: 8'($urandom_range(255, 0)), has_byte: 1'b0, is_last: 1'b1};
      text_q.push_back(it);
    end else begin
      it = text_q.pop_back();
      it.is_last = 1'b1;
      text_q.push_back(it);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic offer(input utf8_vcc_pkg::text_item_t it, input typed_result_t tr,
                       input int gap);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.payload <= it;
    text_ch.valid   <= 1'b1;
    typed_q.push_back(tr);
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    utf8_vcc_pkg::result_item_t got;
    utf8_vcc_pkg::result_item_t want;
    utf8_vcc_pkg::result_item_t predicted;
    typed_result_t              tr;
    bit                         done;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result text_valid=%0b char_count=%0d",
                     $realtime, got.text_valid, got.char_count);
        end else begin
          want = expected_q.pop_front();
          if (got.text_valid !== want.text_valid || got.char_count !== want.char_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: expected text_valid=%0b char_count=%0d, got %0b %0d",
                       $realtime, want.text_valid, want.char_count,
                       got.text_valid, got.char_count);
          end
        end
      end
      if (text_ch.valid && text_ch.ready) begin
        tr = typed_q.pop_front();
        decode_item(text_ch.payload, done, predicted);
        if (done) expected_q.push_back(tr.pinned ? tr.res : predicted);
      end
    end
  end

  initial begin : stimulus
    typed_result_t            tr;
    utf8_vcc_pkg::text_item_t it;
    dir_row_t                 row;
    int                       items_sent;
    int                       text_idx;
    bit                       burst;
    dec_follow   = 0;
    dec_acc      = '0;
    dec_class    = utf8_vcc_pkg::CLASS_NONE;
    dec_bytes    = 0;
    dec_chars    = 0;
    dec_err      = 1'b0;
    results_seen = 0;
    mismatches   = 0;
    text_ch.valid   = 1'b0;
    text_ch.payload = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_TAB[i]) begin
      row = DIRECTED_TAB[i];
      it  = '{data_byte: row.data_byte, has_byte: row.has_byte, is_last: row.is_last};
      tr  = '{pinned: row.pinned, res: '{text_valid: row.ok, char_count: row.count}};
      offer(it, tr, idle_cycles(1'b0));
    end

    items_sent = 0;
    text_idx   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      build_random_text();
      foreach (text_q[i]) if (text_q[i].has_byte || text_q[i].is_last) items_sent++;
      burst = (text_idx % 5 == 4);
      foreach (text_q[i])
        offer(text_q[i], typed_result_t'('0), idle_cycles(burst));
      text_idx++;
    end
    text_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("utf8_validating_char_counter_core regression: pass");
    else
      $display("utf8_validating_char_counter_core regression: fail");
    $finish;
  end

  initial begin : result_drain
    int n;
    bit stall_done;
    stall_done = 1'b0;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      // one long hold-off so the result register fills and the input stalls
      if (!stall_done && results_seen >= 40) begin
        stall_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end
      n = idle_cycles((results_seen / 16) % 3 == 2);
      if (n > 0) begin
        result_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      @(negedge clk);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("utf8_validating_char_counter_core regression: fail");
    $finish;
  end

endmodule
